[hw/rtl/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_BITS  = 16;
  localparam int KEY_BITS = 8;
  localparam int OCC_BITS = $clog2(DEPTH + 1);

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [ID_BITS-1:0]  customer_id;
    logic [KEY_BITS-1:0] priority_key;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [ID_BITS-1:0]  served_id;
    logic [KEY_BITS-1:0] served_key;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One slot of the sorted cell row: compare, hold, shift down or shift up.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  logic      prev_ins,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output logic      ins,
  output entry_t    ent
);

  // New entry belongs at or before this slot.
  assign ins = !valid || (ent.key < ctl.ent.key);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (ins) begin
        ent <= prev_ins ? prev_ent : ctl.ent;
      end
    end else if (ctl.deq) begin
      ent <= next_ent;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stable_priority_queue.sv]
// Top level of the stable priority queue: cell row, occupancy and response register.
`default_nettype none

// Bounded max-priority queue of DEPTH entries held as a row of cells in
// descending key order; equal keys leave in arrival order. Every cell
// compares its key with the incoming key in the same cycle, so the block
// takes one transaction per clock unless rsp is stalled; its response is
// registered and shows on rsp in the cycle after acceptance. req_stall is
// high only while a response waits on a stalled rsp channel. Enqueue into
// a full queue is dropped with status full; dequeue from an empty queue
// returns status empty with zero id and key.
module stable_priority_queue import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [OCC_BITS-1:0] occ;
  logic [OCC_BITS-1:0] occ_next;
  logic                accept;
  logic                full;
  logic                empty;
  cell_ctl_t           ctl;
  rsp_t                rsp_next;
  logic   [DEPTH-1:0]  ins;
  entry_t [DEPTH-1:0]  ent;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (occ == OCC_BITS'(DEPTH));
  assign empty     = (occ == '0);

  assign ctl.enq     = accept && (req.action == ACT_ENQUEUE) && !full;
  assign ctl.deq     = accept && (req.action == ACT_DEQUEUE) && !empty;
  assign ctl.ent.id  = req.customer_id;
  assign ctl.ent.key = req.priority_key;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   valid;
      logic   prev_ins;
      entry_t prev_ent;
      entry_t next_ent;

      assign valid = (occ > OCC_BITS'(i));

      if (i == 0) begin : g_head
        assign prev_ins = 1'b0;
        assign prev_ent = '0;
      end else begin : g_body
        assign prev_ins = ins[i-1];
        assign prev_ent = ent[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign next_ent = '0;
      end else begin : g_mid
        assign next_ent = ent[i+1];
      end

      spq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .valid    (valid),
        .prev_ins (prev_ins),
        .prev_ent (prev_ent),
        .next_ent (next_ent),
        .ins      (ins[i]),
        .ent      (ent[i])
      );
    end
  endgenerate

  always_comb begin
    occ_next = occ;
    if (ctl.enq) begin
      occ_next = occ + OCC_BITS'(1);
    end else if (ctl.deq) begin
      occ_next = occ - OCC_BITS'(1);
    end
  end

  always_comb begin
    rsp_next = '0;
    if (req.action == ACT_ENQUEUE) begin
      rsp_next.status = full ? ST_FULL : ST_ENQUEUED;
    end else if (empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status     = ST_SERVED;
      rsp_next.served_id  = ent[0].id;
      rsp_next.served_key = ent[0].key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      occ       <= occ_next;
      rsp_valid <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spq_check.sv]
// Port-level checker for the stable priority queue, bound to the top level.
`default_nettype none

module spq_check import spq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // Request side stalls only behind a waiting response.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a pending response");

  // Each accepted transaction yields a response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted transaction produced no response");

  // Only a served response carries an id and key.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_SERVED) |-> rsp.served_id == '0 && rsp.served_key == '0)
    else $error("non-served response carries data");

endmodule

bind stable_priority_queue spq_check u_spq_check (.*);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for stable_priority_queue: sorted-order predictor, random traffic, stalls.
`default_nettype none

module tb;
  import spq_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 5;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  stable_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted queue contents, head at index 0.
  logic [ID_BITS-1:0]  pq_id  [DEPTH];
  logic [KEY_BITS-1:0] pq_key [DEPTH];
  int                  pq_count = 0;

  rsp_t pending_responses [$];
  rsp_t want_rsp;
  int   errors      = 0;
  int   idle_cycles = 0;
  int   stall_pct   = 25;
  int   hold_reqs   = 0;
  int   hold_seen   = 0;
  int   stall_left  = 0;
  bit   sender_gaps = 1'b1;

  function automatic rsp_t predict_response(req_t item);
    rsp_t o;
    int   pos;
    int   i;
    o = '0;
    if (item.action == ACT_ENQUEUE) begin
      if (pq_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < pq_count && pq_key[pos] >= item.priority_key) pos++;
        for (i = pq_count; i > pos; i--) begin
          pq_id[i]  = pq_id[i-1];
          pq_key[i] = pq_key[i-1];
        end
        pq_id[pos]  = item.customer_id;
        pq_key[pos] = item.priority_key;
        pq_count++;
        o.status = ST_ENQUEUED;
      end
    end else if (pq_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.status     = ST_SERVED;
      o.served_id  = pq_id[0];
      o.served_key = pq_key[0];
      for (i = 1; i < pq_count; i++) begin
        pq_id[i-1]  = pq_id[i];
        pq_key[i-1] = pq_key[i];
      end
      pq_count--;
    end
    return o;
  endfunction

  // Mostly zero or short, occasionally long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic req_t make_req(action_t act, logic [ID_BITS-1:0] id,
                                    logic [KEY_BITS-1:0] key);
    req_t r;
    r.action       = act;
    r.customer_id  = id;
    r.priority_key = key;
    return r;
  endfunction

  task automatic send_item(input req_t item, input int gap);
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_responses.push_back(predict_response(item));
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic test_empty_dequeue();
    send_item(make_req(ACT_DEQUEUE, 16'h5a5a, 8'ha5), 0);
    wait_drained();
  endtask

  // Extremes of id and key, ties at the head and in the middle, then drain past empty.
  task automatic test_priority_order();
    send_item(make_req(ACT_ENQUEUE, 16'h0000, 8'h00), 0);
    send_item(make_req(ACT_ENQUEUE, 16'hffff, 8'hff), 0);
    send_item(make_req(ACT_ENQUEUE, 16'h1234, 8'h80), 1);
    send_item(make_req(ACT_ENQUEUE, 16'habcd, 8'h80), 0);
    send_item(make_req(ACT_ENQUEUE, 16'h5555, 8'h80), 2);
    send_item(make_req(ACT_ENQUEUE, 16'haaaa, 8'hff), 0);
    send_item(make_req(ACT_DEQUEUE, 16'hffff, 8'hff), 0);
    repeat (6) send_item(make_req(ACT_DEQUEUE, 16'h0000, 8'h00), pick_gap());
    wait_drained();
  endtask

  // Receiver holds off while enqueues keep coming: input stalls, queue fills, overflow drops.
  task automatic test_backpressure_fill();
    hold_reqs <= hold_reqs + 1;
    repeat (DEPTH + 4)
      send_item(make_req(ACT_ENQUEUE, 16'($urandom), 8'($urandom_range(0, 7))), 0);
    repeat (DEPTH + 4)
      send_item(make_req(ACT_DEQUEUE, 16'($urandom), 8'($urandom)), pick_gap());
    wait_drained();
  endtask

  task automatic test_random_mix(input int n, input int enq_pct, input int key_max);
    action_t act;
    int      gap;
    repeat (n) begin
      act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
      gap = sender_gaps ? pick_gap() : 0;
      send_item(make_req(act, 16'($urandom), 8'($urandom_range(0, key_max))), gap);
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(input int n);
    stall_pct   <= 0;
    sender_gaps = 1'b0;
    test_random_mix(n, 55, 255);
    sender_gaps = 1'b1;
    stall_pct   <= 25;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  = hold_reqs;
      stall_left = HOLD_CYCLES;
      rsp_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = pick_gap();
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected transaction, actual status=%0d id=%h key=%h",
                 $time, rsp.status, rsp.served_id, rsp.served_key);
        errors++;
      end else begin
        want_rsp = pending_responses.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want_rsp.status, rsp.status);
          errors++;
        end
        if (rsp.served_id !== want_rsp.served_id) begin
          $display("%0t: served_id mismatch, expected %h actual %h",
                   $time, want_rsp.served_id, rsp.served_id);
          errors++;
        end
        if (rsp.served_key !== want_rsp.served_key) begin
          $display("%0t: served_key mismatch, expected %h actual %h",
                   $time, want_rsp.served_key, rsp.served_key);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_dequeue();
    test_priority_order();
    test_backpressure_fill();
    test_random_mix(110, 70, 255);
    test_random_mix(110, 50, 3);
    test_random_mix(110, 30, 255);
    test_back_to_back(40);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived",
               $time, pending_responses.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[stable_priority_queue.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
hw/rtl/spq_check.sv
tb/sv/tb.sv
